// File: hw/rtl/qnl_pkg.sv
// qnl_pkg: widths, constants and sideband type for the quaternion nlerp pipeline.
// No dependencies; imported by qnl_isqrt and quaternion_nlerp.
package qnl_pkg;

    localparam int NCOMP       = 4;
    localparam int COMP_W      = 16;
    localparam int BLEND_W     = 15;
    localparam int FRAC_W      = 14;
    localparam logic [BLEND_W-1:0] ONE_Q14 = 15'd16384;

    localparam int PROD_W      = 31;
    localparam int MAG_W       = 30;
    localparam logic [MAG_W-1:0] MAG_MAX = 30'd536870912;
    localparam int SQ_W        = 60;
    localparam int SUM_W       = 61;

    localparam int RAD_W       = 62;
    localparam int ROOT_W      = 31;
    localparam int REM_W       = 32;
    localparam int ROOT_STAGES = 31;

    localparam int DIV_W       = 44;
    localparam int Q_W         = 15;
    localparam int DIV_STAGES  = 15;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 64;

    typedef struct packed {
        logic [NCOMP-1:0][MAG_W-1:0] mag;
        logic [NCOMP-1:0]            neg;
        logic                        zero;
    } side_t;

endpackage

// File: hw/rtl/qnl_isqrt.sv
// qnl_isqrt: pipelined integer square root, one result bit per stage.
// Depends on qnl_pkg; sideband of type side_t travels with each item.
module qnl_isqrt import qnl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SUM_W-1:0]  in_rad,
    input  side_t             in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    localparam int LAST = ROOT_STAGES - 1;

    logic [ROOT_STAGES-1:0] v_reg;
    logic [ROOT_STAGES-1:0] adv;
    logic [ROOT_STAGES-1:0] v_in;
    logic [RAD_W-1:0]       rad_reg   [ROOT_STAGES];
    logic [ROOT_W-1:0]      root_reg  [ROOT_STAGES];
    logic [REM_W-1:0]       rem_reg   [ROOT_STAGES];
    side_t                  side_reg  [ROOT_STAGES];
    logic [RAD_W-1:0]       rad_next  [ROOT_STAGES];
    logic [ROOT_W-1:0]      root_next [ROOT_STAGES];
    logic [REM_W-1:0]       rem_next  [ROOT_STAGES];
    side_t                  side_in   [ROOT_STAGES];

    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in[k]    = in_valid;
            assign rad_in     = {{(RAD_W-SUM_W){1'b0}}, in_rad};
            assign root_in    = '0;
            assign rem_in     = '0;
            assign side_in[k] = in_side;
        end
        else begin : g_rest
            assign v_in[k]    = v_reg[k-1];
            assign rad_in     = rad_reg[k-1];
            assign root_in    = root_reg[k-1];
            assign rem_in     = rem_reg[k-1];
            assign side_in[k] = side_reg[k-1];
        end

        if (k == LAST) begin : g_tail
            assign adv[k] = !v_reg[k] || out_ready;
        end
        else begin : g_mid
            assign adv[k] = !v_reg[k] || adv[k+1];
        end

        assign cur          = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial        = {1'b0, root_in, 2'b01};
        assign diff         = cur - trial;
        assign ge           = cur >= trial;
        assign rem_next[k]  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        assign root_next[k] = {root_in[ROOT_W-2:0], ge};
        assign rad_next[k]  = {rad_in[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < ROOT_STAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_STAGES; k++)
        begin
            if (adv[k])
            begin
                rad_reg[k]  <= rad_next[k];
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[LAST];
    assign out_root  = root_reg[LAST];
    assign out_side  = side_reg[LAST];

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rem_reg[LAST] <= {root_reg[LAST], 1'b0})
        else $error("isqrt remainder exceeds twice the root");

    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_side.zero |-> out_root == '0)
        else $error("zero-length item has nonzero root");

endmodule

// File: hw/rtl/quaternion_nlerp.sv
// quaternion_nlerp: normalized linear blend of two Q1.14 quaternions, top level.
// Depends on qnl_pkg and qnl_isqrt.
//
//  group   dir  tdata fields (low bit up)                          tuser
//  s_axis  in   a_x a_y a_z a_w b_x b_y b_z b_w blend, 1 pad bit   -
//  m_axis  out  res_x res_y res_z res_w                            zero_length
//
// One item per cycle unless m_axis stalls, through 4 blend/square/sum stages, a 31-stage
// root pipeline (one root bit per stage), divider setup, a 15-stage divider
// (one quotient bit per stage) and the output register.
// rst_n clears all valid bits; payload registers are not reset.
// Each stage loads when it is empty or its successor loads, so bubbles close up
// under m_axis stalls and s_axis_tready stays high while any stage has room.
module quaternion_nlerp import qnl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // a_x,a_y,a_z,a_w,b_x,b_y,b_z,b_w,blend
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // res_x,res_y,res_z,res_w
    output logic [0:0]             m_axis_tuser    // zero_length
);

    localparam int DLAST = DIV_STAGES - 1;

    // blend products
    logic [BLEND_W-1:0]       blend_in;
    logic [BLEND_W-1:0]       t_clamp;
    logic [BLEND_W-1:0]       t_comp;
    logic signed [2*COMP_W-1:0] pa_full [NCOMP];
    logic signed [2*COMP_W-1:0] pb_full [NCOMP];
    logic signed [PROD_W-1:0] prod_a_reg [NCOMP];
    logic signed [PROD_W-1:0] prod_b_reg [NCOMP];
    logic                     v_prod_reg;
    logic                     adv_prod;

    always_comb
    begin
        blend_in = s_axis_tdata[2*NCOMP*COMP_W +: BLEND_W];
        t_clamp  = (blend_in > ONE_Q14) ? ONE_Q14 : blend_in;
        t_comp   = ONE_Q14 - t_clamp;
        for (int c = 0; c < NCOMP; c++)
        begin
            pa_full[c] = $signed(s_axis_tdata[c*COMP_W +: COMP_W]) * $signed({1'b0, t_comp});
            pb_full[c] = $signed(s_axis_tdata[(c+NCOMP)*COMP_W +: COMP_W])
                         * $signed({1'b0, t_clamp});
        end
    end

    // blended magnitudes
    logic signed [PROD_W-1:0] o_sum  [NCOMP];
    logic [PROD_W-1:0]        o_abs  [NCOMP];
    logic [MAG_W-1:0]         mag_next [NCOMP];
    logic [NCOMP-1:0]         neg_next;
    logic [MAG_W-1:0]         mag_reg [NCOMP];
    logic [NCOMP-1:0]         neg_reg;
    logic                     v_mag_reg;
    logic                     adv_mag;

    always_comb
    begin
        for (int c = 0; c < NCOMP; c++)
        begin
            o_sum[c]    = prod_a_reg[c] + prod_b_reg[c];
            neg_next[c] = o_sum[c][PROD_W-1];
            o_abs[c]    = neg_next[c] ? PROD_W'(-o_sum[c]) : PROD_W'(o_sum[c]);
            mag_next[c] = o_abs[c][MAG_W-1:0];
        end
    end

    // squares
    logic [SQ_W-1:0] sq_next [NCOMP];
    logic [SQ_W-1:0] sq_reg  [NCOMP];
    side_t           side_sq_next;
    side_t           side_sq_reg;
    logic            v_sq_reg;
    logic            adv_sq;

    always_comb
    begin
        side_sq_next.zero = 1'b1;
        for (int c = 0; c < NCOMP; c++)
        begin
            sq_next[c]           = SQ_W'(mag_reg[c]) * SQ_W'(mag_reg[c]);
            side_sq_next.mag[c]  = mag_reg[c];
            side_sq_next.neg[c]  = neg_reg[c];
            side_sq_next.zero    = side_sq_next.zero && (mag_reg[c] == '0);
        end
    end

    // sum of squares
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    side_t            side_sum_reg;
    logic             v_sum_reg;
    logic             adv_sum;
    logic             rt_in_ready;

    assign sum_next = (SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]))
                    + (SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]));

    // root
    logic              rt_valid;
    logic [ROOT_W-1:0] rt_root;
    side_t             rt_side;
    logic              adv_d;

    qnl_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_sum_reg),
        .in_ready  (rt_in_ready),
        .in_rad    (sum_reg),
        .in_side   (side_sum_reg),
        .out_valid (rt_valid),
        .out_ready (adv_d),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    // divider setup: dividend = mag * 2^14 + floor(L / 2)
    logic [DIV_W-1:0]  dd_next [NCOMP];
    logic [DIV_W-1:0]  dd_reg  [NCOMP];
    logic [ROOT_W-1:0] dl_reg;
    logic [NCOMP-1:0]  dneg_reg;
    logic              dzero_reg;
    logic              v_d_reg;

    always_comb
    begin
        for (int c = 0; c < NCOMP; c++)
        begin
            dd_next[c] = {rt_side.mag[c], {FRAC_W{1'b0}}} + DIV_W'(rt_root >> 1);
        end
    end

    // restoring divider, one quotient bit per stage
    logic [DIV_STAGES-1:0] v_dv_reg;
    logic [DIV_STAGES-1:0] adv_dv;
    logic [DIV_STAGES-1:0] dv_v_in;
    logic [ROOT_W-1:0]     dvl_reg    [DIV_STAGES];
    logic [NCOMP-1:0]      dvneg_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] dvzero_reg;
    logic [ROOT_W-1:0]     dvl_in     [DIV_STAGES];
    logic [NCOMP-1:0]      dvneg_in   [DIV_STAGES];
    logic [DIV_STAGES-1:0] dvzero_in;
    logic [ROOT_W-1:0]     rm_reg     [DIV_STAGES][NCOMP];
    logic [Q_W-1:0]        lq_reg     [DIV_STAGES][NCOMP];
    logic [ROOT_W-1:0]     rm_next    [DIV_STAGES][NCOMP];
    logic [Q_W-1:0]        lq_next    [DIV_STAGES][NCOMP];
    logic                  adv_out;

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [ROOT_W-1:0] r_in  [NCOMP];
        logic [Q_W-1:0]    lq_in [NCOMP];

        if (j == 0) begin : g_first
            assign dv_v_in[j]   = v_d_reg;
            assign dvl_in[j]    = dl_reg;
            assign dvneg_in[j]  = dneg_reg;
            assign dvzero_in[j] = dzero_reg;
            for (genvar c = 0; c < NCOMP; c++) begin : g_ld
                assign r_in[c]  = ROOT_W'(dd_reg[c][DIV_W-1:Q_W]);
                assign lq_in[c] = dd_reg[c][Q_W-1:0];
            end
        end
        else begin : g_rest
            assign dv_v_in[j]   = v_dv_reg[j-1];
            assign dvl_in[j]    = dvl_reg[j-1];
            assign dvneg_in[j]  = dvneg_reg[j-1];
            assign dvzero_in[j] = dvzero_reg[j-1];
            for (genvar c = 0; c < NCOMP; c++) begin : g_ld
                assign r_in[c]  = rm_reg[j-1][c];
                assign lq_in[c] = lq_reg[j-1][c];
            end
        end

        if (j == DLAST) begin : g_tail
            assign adv_dv[j] = !v_dv_reg[j] || adv_out;
        end
        else begin : g_mid
            assign adv_dv[j] = !v_dv_reg[j] || adv_dv[j+1];
        end

        for (genvar c = 0; c < NCOMP; c++) begin : g_lane
            logic [ROOT_W:0] cur;
            logic [ROOT_W:0] diff;
            logic            ge;

            assign cur           = {r_in[c], lq_in[c][Q_W-1]};
            assign diff          = cur - {1'b0, dvl_in[j]};
            assign ge            = cur >= {1'b0, dvl_in[j]};
            assign rm_next[j][c] = ge ? diff[ROOT_W-1:0] : cur[ROOT_W-1:0];
            assign lq_next[j][c] = {lq_in[c][Q_W-2:0], ge};
        end
    end

    // output
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_zero_reg;
    logic                   v_out_reg;
    logic [COMP_W-1:0]      q_ext [NCOMP];

    always_comb
    begin
        for (int c = 0; c < NCOMP; c++)
        begin
            q_ext[c] = {1'b0, lq_reg[DLAST][c]};
            if (dvzero_reg[DLAST])
            begin
                out_data_next[c*COMP_W +: COMP_W] = '0;
            end
            else if (dvneg_reg[DLAST][c])
            begin
                out_data_next[c*COMP_W +: COMP_W] = COMP_W'(0) - q_ext[c];
            end
            else
            begin
                out_data_next[c*COMP_W +: COMP_W] = q_ext[c];
            end
        end
    end

    // stage handshake
    assign adv_out       = !v_out_reg || m_axis_tready;
    assign adv_d         = !v_d_reg || adv_dv[0];
    assign adv_sum       = !v_sum_reg || rt_in_ready;
    assign adv_sq        = !v_sq_reg || adv_sum;
    assign adv_mag       = !v_mag_reg || adv_sq;
    assign adv_prod      = !v_prod_reg || adv_mag;
    assign s_axis_tready = adv_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_prod_reg <= 1'b0;
            v_mag_reg  <= 1'b0;
            v_sq_reg   <= 1'b0;
            v_sum_reg  <= 1'b0;
            v_d_reg    <= 1'b0;
            v_dv_reg   <= '0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            if (adv_prod)
            begin
                v_prod_reg <= s_axis_tvalid;
            end
            if (adv_mag)
            begin
                v_mag_reg <= v_prod_reg;
            end
            if (adv_sq)
            begin
                v_sq_reg <= v_mag_reg;
            end
            if (adv_sum)
            begin
                v_sum_reg <= v_sq_reg;
            end
            if (adv_d)
            begin
                v_d_reg <= rt_valid;
            end
            for (int j = 0; j < DIV_STAGES; j++)
            begin
                if (adv_dv[j])
                begin
                    v_dv_reg[j] <= dv_v_in[j];
                end
            end
            if (adv_out)
            begin
                v_out_reg <= v_dv_reg[DLAST];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_prod)
        begin
            for (int c = 0; c < NCOMP; c++)
            begin
                prod_a_reg[c] <= pa_full[c][PROD_W-1:0];
                prod_b_reg[c] <= pb_full[c][PROD_W-1:0];
            end
        end
        if (adv_mag)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (adv_sq)
        begin
            sq_reg      <= sq_next;
            side_sq_reg <= side_sq_next;
        end
        if (adv_sum)
        begin
            sum_reg      <= sum_next;
            side_sum_reg <= side_sq_reg;
        end
        if (adv_d)
        begin
            dd_reg    <= dd_next;
            dl_reg    <= rt_root;
            dneg_reg  <= rt_side.neg;
            dzero_reg <= rt_side.zero;
        end
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (adv_dv[j])
            begin
                dvl_reg[j]    <= dvl_in[j];
                dvneg_reg[j]  <= dvneg_in[j];
                dvzero_reg[j] <= dvzero_in[j];
                rm_reg[j]     <= rm_next[j];
                lq_reg[j]     <= lq_next[j];
            end
        end
        if (adv_out)
        begin
            out_data_reg <= out_data_next;
            out_zero_reg <= dvzero_reg[DLAST];
        end
    end

    assign m_axis_tvalid   = v_out_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_zero_reg;

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_mag_reg |-> mag_reg[0] <= MAG_MAX && mag_reg[1] <= MAG_MAX
                   && mag_reg[2] <= MAG_MAX && mag_reg[3] <= MAG_MAX)
        else $error("blended magnitude out of range");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_d_reg && !dzero_reg |-> dl_reg != '0)
        else $error("nonzero blend produced zero length");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_dv_reg[DLAST] && !dvzero_reg[DLAST]
        |-> lq_reg[DLAST][0] <= ONE_Q14 && lq_reg[DLAST][1] <= ONE_Q14
         && lq_reg[DLAST][2] <= ONE_Q14 && lq_reg[DLAST][3] <= ONE_Q14)
        else $error("normalized component above one");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("zero-length item with nonzero components");

endmodule
